[hw/rtl/nec_ir_frame_decoder_defines.svh]
// Assertion macros shared by the NEC IR frame decoder RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef NEC_IR_FRAME_DECODER_DEFINES_SVH
`define NEC_IR_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define NEC_ASSERT_SAME(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define NEC_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

[hw/rtl/nec_ir_pkg.sv]
// Shared types and constants of the NEC IR frame decoder.
// No dependencies; imported by nec_ir_core and nec_ir_frame_decoder.
`timescale 1ns / 1ps

package nec_ir_pkg;

   localparam int TICK_FIELD_BITS = 16;
   localparam int KEY_BITS        = 16;
   localparam int RATE_BITS       = 8;
   localparam int NEC_DATA_BITS   = 32;
   localparam int BIT_IDX_BITS    = $clog2(NEC_DATA_BITS);

   localparam logic [TICK_FIELD_BITS-1:0] HEADER_THRESHOLD_RESET = 16'd4200;
   localparam logic [TICK_FIELD_BITS-1:0] ONE_THRESHOLD_RESET    = 16'd1650;
   localparam logic [RATE_BITS-1:0]       REPEAT_RATE_RESET      = 8'd10;

   typedef enum logic [1:0] {
      CSR_HEADER_THRESHOLD = 2'd0,
      CSR_ONE_THRESHOLD    = 2'd1,
      CSR_REPEAT_RATE      = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [TICK_FIELD_BITS-1:0] header_threshold;
      logic [TICK_FIELD_BITS-1:0] one_threshold;
      logic [RATE_BITS-1:0]       repeat_rate;
   } cfg_type;

   typedef struct packed {
      logic                valid;
      logic [KEY_BITS-1:0] key_code;
      logic                is_repeat;
   } result_type;

endpackage

[hw/rtl/nec_ir_core.sv]
// Frame state and decode logic of the NEC IR frame decoder.
// Depends on nec_ir_pkg for the configuration and result structs.
`timescale 1ns / 1ps

module nec_ir_core #(
   parameter int TICK_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    step,
   input  logic [nec_ir_pkg::TICK_FIELD_BITS-1:0]  interval_ticks,
   input  logic                                    first_of_frame,
   input  nec_ir_pkg::cfg_type                     cfg,
   output nec_ir_pkg::result_type                  result
);
   import nec_ir_pkg::*;

   // Only the low TICK_BITS of the field and thresholds take part in compares.
   localparam int CMP_BITS = (TICK_BITS < TICK_FIELD_BITS) ? TICK_BITS : TICK_FIELD_BITS;
   localparam logic [BIT_IDX_BITS-1:0] LAST_BIT = BIT_IDX_BITS'(NEC_DATA_BITS - 1);

   logic                    collecting_ff, collecting_in;
   logic [BIT_IDX_BITS-1:0] bit_index_ff, bit_index_in;
   logic [KEY_BITS-1:0]     code_shift_ff, code_shift_in;
   logic [KEY_BITS-1:0]     inverse_shift_ff, inverse_shift_in;
   logic [KEY_BITS-1:0]     last_key_ff, last_key_in;
   logic [RATE_BITS-1:0]    repeat_counter_ff, repeat_counter_in;

   logic                    long_header;
   logic                    data_bit;
   logic [RATE_BITS-1:0]    counter_inc;

   assign long_header = interval_ticks[CMP_BITS-1:0] > cfg.header_threshold[CMP_BITS-1:0];
   assign data_bit    = interval_ticks[CMP_BITS-1:0] > cfg.one_threshold[CMP_BITS-1:0];
   assign counter_inc = repeat_counter_ff + RATE_BITS'(1);

   always_comb begin
      collecting_in     = collecting_ff;
      bit_index_in      = bit_index_ff;
      code_shift_in     = code_shift_ff;
      inverse_shift_in  = inverse_shift_ff;
      last_key_in       = last_key_ff;
      repeat_counter_in = repeat_counter_ff;
      result            = '0;

      if (first_of_frame) begin
         collecting_in = 1'b0;
         if (long_header) begin
            repeat_counter_in = '0;
            collecting_in     = 1'b1;
            bit_index_in      = '0;
            code_shift_in     = '0;
            inverse_shift_in  = '0;
         end else if (counter_inc == cfg.repeat_rate) begin
            repeat_counter_in = '0;
            result.valid      = 1'b1;
            result.key_code   = last_key_ff;
            result.is_repeat  = 1'b1;
         end else begin
            repeat_counter_in = counter_inc;
         end
      end else if (collecting_ff) begin
         // Bytes 0 and 2 have index bit 3 clear; bytes 1 and 3 have it set.
         if (!bit_index_ff[3]) begin
            code_shift_in = {code_shift_ff[KEY_BITS-2:0], data_bit};
         end else begin
            inverse_shift_in = {inverse_shift_ff[KEY_BITS-2:0], data_bit};
         end
         bit_index_in = bit_index_ff + BIT_IDX_BITS'(1);
         if (bit_index_ff == LAST_BIT) begin
            collecting_in = 1'b0;
            bit_index_in  = '0;
            if (code_shift_in == ~inverse_shift_in) begin
               last_key_in      = code_shift_in;
               result.valid     = 1'b1;
               result.key_code  = code_shift_in;
               result.is_repeat = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         collecting_ff     <= 1'b0;
         bit_index_ff      <= '0;
         code_shift_ff     <= '0;
         inverse_shift_ff  <= '0;
         last_key_ff       <= '0;
         repeat_counter_ff <= '0;
      end else if (step) begin
         collecting_ff     <= collecting_in;
         bit_index_ff      <= bit_index_in;
         code_shift_ff     <= code_shift_in;
         inverse_shift_ff  <= inverse_shift_in;
         last_key_ff       <= last_key_in;
         repeat_counter_ff <= repeat_counter_in;
      end
   end

endmodule

[hw/rtl/nec_ir_frame_decoder.sv]
// An accepted interval is registered in the input stage, decoded out of it and
// registered in the result register once the stage advances; a frame result
// follows its 32nd data bit, a repeat follows its header. Throughput: one
// interval per cycle while rsp_tready is high; the input stage and the result
// register are the only pipeline elements. Reset (synchronous, active high)
// clears the valid flags, core state and configuration, not the payload registers.
`timescale 1ns / 1ps
`include "nec_ir_frame_decoder_defines.svh"

module nec_ir_frame_decoder #(
   parameter int TICK_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Input stream. tdata: interval_ticks[15:0]. tuser: first_of_frame[0].
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        req_tuser,
   // Result stream. tdata: key_code[15:0]. tuser: is_repeat[0].
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   output logic        rsp_tuser,
   // Register write channel: index selects header_threshold, one_threshold
   // or repeat_rate; an index past the list is accepted and ignored.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import nec_ir_pkg::*;

   // Input stage: one registered transaction waiting for the decode logic.
   logic                       s1_valid_ff, s1_valid_in;
   logic [TICK_FIELD_BITS-1:0] s1_ticks_ff;
   logic                       s1_header_ff;

   // Result register that decouples the result stream from the input side.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [KEY_BITS-1:0] rsp_key_ff;
   logic                rsp_repeat_ff;

   cfg_type    cfg_ff;
   result_type core_result;
   logic       advance;
   logic       req_fire;

   // The input stage moves on whenever the result register is free or is
   // being emptied in this cycle.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_key_ff;
   assign rsp_tuser  = rsp_repeat_ff;

   nec_ir_core #(
      .TICK_BITS (TICK_BITS)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .step           (s1_valid_ff && advance),
      .interval_ticks (s1_ticks_ff),
      .first_of_frame (s1_header_ff),
      .cfg            (cfg_ff),
      .result         (core_result)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = s1_valid_ff && core_result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ticks_ff  <= req_tdata;
         s1_header_ff <= req_tuser;
      end
      if (advance && s1_valid_ff && core_result.valid) begin
         rsp_key_ff    <= core_result.key_code;
         rsp_repeat_ff <= core_result.is_repeat;
      end
   end

   // Configuration registers; the user must issue writes only while the block is idle (not enforced here).
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_threshold <= HEADER_THRESHOLD_RESET;
         cfg_ff.one_threshold    <= ONE_THRESHOLD_RESET;
         cfg_ff.repeat_rate      <= REPEAT_RATE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_HEADER_THRESHOLD: cfg_ff.header_threshold <= csr_data;
            CSR_ONE_THRESHOLD:    cfg_ff.one_threshold    <= csr_data;
            CSR_REPEAT_RATE:      cfg_ff.repeat_rate      <= csr_data[RATE_BITS-1:0];
            default: ;
         endcase
      end
   end

   `NEC_ASSERT_SAME(a_ready_when_empty, clock, reset, !s1_valid_ff, req_tready, "input stage empty but not ready")
   `NEC_ASSERT_NEXT(a_accept_loads_stage, clock, reset, req_fire, s1_valid_ff, "accepted transaction lost at input stage")
   `NEC_ASSERT_NEXT(a_stall_holds_stage, clock, reset, s1_valid_ff && !advance, s1_valid_ff && $stable(s1_ticks_ff) && $stable(s1_header_ff), "stalled input stage changed")
   `NEC_ASSERT_NEXT(a_result_registered, clock, reset, s1_valid_ff && advance && core_result.valid, rsp_valid_ff, "decoded result not registered")

endmodule

[tb/sv/tb_nec_ir_frame_decoder.sv]
// Self-checking testbench of nec_ir_frame_decoder: directed and random IR intervals in,
// decoded keys out, checked against a behavioral decoder held in a small scoreboard class.
// Depends on nec_ir_pkg and the nec_ir_frame_decoder RTL only.
`timescale 1ns / 1ps

module tb_nec_ir_frame_decoder;
   import nec_ir_pkg::*;

   // The register channel is two bits wide; this index lies past the register list.
   localparam logic [1:0] UNUSED_CSR_INDEX = 2'd3;
   localparam int IDLE_PCT      = 22;
   localparam int HOLD_CYCLES   = 200;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int PIPE_SETTLE   = 8;
   localparam logic [15:0] TICKS_MAX = 16'hFFFF;

   typedef struct packed {
      logic [15:0] key_code;
      logic        is_repeat;
   } key_event_type;

   // Behavioral NEC decoder plus the queue of keys it says the block owes us.
   class nec_key_scoreboard;
      logic [15:0]   header_thr;
      logic [15:0]   one_thr;
      logic [7:0]    rate;
      bit            collecting;
      logic [5:0]    bit_pos;
      logic [15:0]   code_word;
      logic [15:0]   inverse_word;
      logic [15:0]   last_key;
      logic [7:0]    repeat_count;
      key_event_type owed_keys[$];
      int            errors;

      function new();
         header_thr   = HEADER_THRESHOLD_RESET;
         one_thr      = ONE_THRESHOLD_RESET;
         rate         = REPEAT_RATE_RESET;
         collecting   = 1'b0;
         bit_pos      = '0;
         code_word    = '0;
         inverse_word = '0;
         last_key     = '0;
         repeat_count = '0;
         errors       = 0;
      endfunction

      function void write_reg(logic [1:0] index, logic [15:0] value);
         case (index)
            CSR_HEADER_THRESHOLD: header_thr = value;
            CSR_ONE_THRESHOLD:    one_thr    = value;
            CSR_REPEAT_RATE:      rate       = value[7:0];
            default: ;
         endcase
      endfunction

      function void note_interval(logic [15:0] ticks, logic frame_start);
         logic       data_bit;
         logic [5:0] pos;
         if (frame_start) begin
            collecting = 1'b0;
            if (ticks > header_thr) begin
               repeat_count = '0;
               collecting   = 1'b1;
               bit_pos      = '0;
               code_word    = '0;
               inverse_word = '0;
               return;
            end
            repeat_count = repeat_count + 8'd1;
            if (repeat_count == rate) begin
               repeat_count = '0;
               owed_keys.push_back('{key_code: last_key, is_repeat: 1'b1});
            end
            return;
         end
         if (!collecting)
            return;
         data_bit = (ticks > one_thr);
         pos = bit_pos;
         if (pos < 6'd8 || (pos >= 6'd16 && pos < 6'd24))
            code_word = {code_word[14:0], data_bit};
         else
            inverse_word = {inverse_word[14:0], data_bit};
         bit_pos = pos + 6'd1;
         if (bit_pos < 6'd32)
            return;
         collecting = 1'b0;
         bit_pos    = '0;
         if (code_word == ~inverse_word) begin
            last_key = code_word;
            owed_keys.push_back('{key_code: code_word, is_repeat: 1'b0});
         end
      endfunction

      function void check_key(logic [15:0] code, logic rep);
         key_event_type want;
         if (owed_keys.size() == 0) begin
            errors++;
            $display("%0t: unexpected key: expected none, actual code %h repeat %b",
                     $time, code, rep);
            return;
         end
         want = owed_keys.pop_front();
         if (code !== want.key_code) begin
            errors++;
            $display("%0t: key_code mismatch: expected %h, actual %h",
                     $time, want.key_code, code);
         end
         if (rep !== want.is_repeat) begin
            errors++;
            $display("%0t: is_repeat mismatch: expected %b, actual %b",
                     $time, want.is_repeat, rep);
         end
      endfunction

      function int pending();
         return owed_keys.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   nec_key_scoreboard sb = new();

   // Register values the stimulus aims its intervals at.
   logic [15:0] cur_hdr = HEADER_THRESHOLD_RESET;
   logic [15:0] cur_one = ONE_THRESHOLD_RESET;
   bit          calm = 1'b0;          // no idling on either side while set
   int          items_sent = 0;
   int          hold_requests = 0;    // bumped by the stimulus to ask for a long hold-off

   nec_ir_frame_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),     // interval_ticks[15:0]
      .req_tuser  (req_tuser),     // first_of_frame[0]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),     // key_code[15:0]
      .rsp_tuser  (rsp_tuser),     // is_repeat[0]
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Result side. Every transaction is checked at the edge that completes it. The
   // ready line idles at random, except during a requested hold-off, which this
   // process counts down itself while the sender keeps offering intervals.
   int hold_left = 0;
   int hold_seen = 0;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_key(rsp_tdata, rsp_tuser);
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_seen != hold_requests) begin
         hold_seen  = hold_requests;
         hold_left  = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Offers one interval and returns at the edge where the transaction completes.
   // The valid line stays high on return, so back-to-back intervals never drop it;
   // it is lowered only when a gap is chosen or when a phase ends.
   task automatic send_interval(input logic [15:0] ticks, input logic frame_start);
      if (!calm) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ticks;
      req_tuser  <= frame_start;
      do @(posedge clock); while (!req_tready);
      sb.note_interval(ticks, frame_start);
      items_sent++;
   endtask

   // Waits until every owed key has come back, then lets the pipeline settle,
   // since intervals that produce no key may still be in flight.
   task automatic wait_idle();
      int spins;
      spins = 0;
      req_tvalid <= 1'b0;
      while (sb.pending() != 0 && spins < DRAIN_LIMIT) begin
         @(posedge clock);
         spins++;
      end
      repeat (PIPE_SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(index, value);
   endtask

   // One write to the unused index first; the block must accept and drop it.
   task automatic write_settings(input logic [15:0] hdr, input logic [15:0] one,
                                 input logic [7:0] rate);
      write_reg(UNUSED_CSR_INDEX, 16'($urandom_range(16'hFFFF)));
      write_reg(CSR_HEADER_THRESHOLD, hdr);
      write_reg(CSR_ONE_THRESHOLD, one);
      // The upper byte of the rate write carries noise that must be dropped.
      write_reg(CSR_REPEAT_RATE, {8'($urandom_range(255)), rate});
      csr_valid <= 1'b0;
      cur_hdr = hdr;
      cur_one = one;
   endtask

   // Ticks for one data bit under the current threshold, often right at the boundary.
   function automatic logic [15:0] bit_ticks(input logic b);
      if (b) begin
         if (cur_one == TICKS_MAX)
            return TICKS_MAX;
         if ($urandom_range(4) == 0)
            return cur_one + 16'd1;
         return 16'($urandom_range(int'(TICKS_MAX), int'(cur_one) + 1));
      end
      if ($urandom_range(4) == 0)
         return cur_one;
      return 16'($urandom_range(int'(cur_one), 0));
   endfunction

   function automatic logic [15:0] press_ticks();
      if (cur_hdr == TICKS_MAX)
         return TICKS_MAX;
      if ($urandom_range(4) == 0)
         return cur_hdr + 16'd1;
      return 16'($urandom_range(int'(TICKS_MAX), int'(cur_hdr) + 1));
   endfunction

   function automatic logic [15:0] hold_ticks();
      if ($urandom_range(4) == 0)
         return cur_hdr;
      return 16'($urandom_range(int'(cur_hdr), 0));
   endfunction

   // A press header and up to 32 data bits of a frame whose inverse bytes are
   // correct, unless flip_bit names a bit of the 32-bit frame to corrupt.
   task automatic send_frame(input logic [15:0] code, input int flip_bit,
                             input int keep_bits);
      logic [31:0] frame;
      frame = {code[15:8], ~code[15:8], code[7:0], ~code[7:0]};
      if (flip_bit >= 0)
         frame[flip_bit] = ~frame[flip_bit];
      send_interval(press_ticks(), 1'b1);
      for (int i = 0; i < keep_bits; i++)
         send_interval(bit_ticks(frame[31 - i]), 1'b0);
   endtask

   // Mostly whole frames with random codes; some hold repeats, corrupted or cut
   // frames, and raw noise on both fields.
   task automatic random_traffic(input int count, input int repeat_pct);
      int start;
      int pick;
      start = items_sent;
      while (items_sent - start < count) begin
         pick = $urandom_range(99);
         if (pick < repeat_pct) begin
            repeat ($urandom_range(4, 1)) send_interval(hold_ticks(), 1'b1);
         end else if (pick < repeat_pct + 10) begin
            send_interval(16'($urandom_range(16'hFFFF)), 1'($urandom_range(1)));
         end else begin
            pick = $urandom_range(9);
            send_frame(16'($urandom_range(16'hFFFF)),
                       (pick == 0) ? int'($urandom_range(31)) : -1,
                       (pick == 1) ? int'($urandom_range(31)) : 32);
         end
      end
   endtask

   task automatic run_phase(input logic [15:0] hdr, input logic [15:0] one,
                            input logic [7:0] rate, input int count,
                            input int repeat_pct, input bit quiet);
      wait_idle();
      write_settings(hdr, one, rate);
      calm = quiet;
      random_traffic(count, repeat_pct);
   endtask

   initial begin
      logic [31:0] frame;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part, at the power-up register values.
      // Data intervals with no frame open are dropped.
      send_interval(16'h0000, 1'b0);
      send_interval(TICKS_MAX, 1'b0);
      // Ten hold headers before any press re-emit the zero key; a header equal
      // to the threshold still counts as a hold.
      send_interval(16'h0000, 1'b1);
      send_interval(HEADER_THRESHOLD_RESET, 1'b1);
      repeat (8) send_interval(hold_ticks(), 1'b1);
      // A press abandoned by another press, which then completes a frame whose
      // bits sit at the extremes and right at the one threshold.
      send_interval(TICKS_MAX, 1'b1);
      repeat (3) send_interval(bit_ticks(1'b1), 1'b0);
      send_interval(HEADER_THRESHOLD_RESET + 16'd1, 1'b1);
      frame = {8'h12, ~8'h12, 8'hED, ~8'hED};
      for (int i = 0; i < 32; i++) begin
         if (frame[31 - i])
            send_interval(i[0] ? TICKS_MAX : ONE_THRESHOLD_RESET + 16'd1, 1'b0);
         else
            send_interval(i[0] ? 16'h0000 : ONE_THRESHOLD_RESET, 1'b0);
      end
      send_interval(16'h0000, 1'b0);
      // A press cut short by a hold header, which counts as a repeat.
      send_interval(TICKS_MAX, 1'b1);
      repeat (2) send_interval(bit_ticks(1'b0), 1'b0);
      send_interval(16'd100, 1'b1);

      // Random part over several register settings.
      run_phase(HEADER_THRESHOLD_RESET, ONE_THRESHOLD_RESET, REPEAT_RATE_RESET, 30, 20, 1'b0);

      // Low extremes with a key on every hold header. A long hold-off on the
      // result side while holds keep coming fills the block up.
      wait_idle();
      write_settings(16'h0000, 16'h0000, 8'd1);
      hold_requests++;
      repeat (40) send_interval(16'h0000, 1'b1);
      random_traffic(40, 30);

      // High extremes: no header can be a press and no bit can be a one.
      run_phase(TICKS_MAX, TICKS_MAX, 8'd255, 20, 40, 1'b0);

      // A rate of zero wraps the counter, so only every 256th hold re-emits.
      wait_idle();
      write_settings(16'($urandom_range(60000, 1000)), 16'($urandom_range(60000, 100)),
                     8'd0);
      repeat (260) send_interval(hold_ticks(), 1'b1);
      random_traffic(10, 20);

      // Random thresholds and a small rate, with both sides never idling.
      run_phase(16'($urandom_range(16'hFFFE)), 16'($urandom_range(16'hFFFE)),
                8'($urandom_range(6, 1)), 40, 25, 1'b1);
      run_phase(16'd1, 16'hFFFE, 8'd2, 20, 30, 1'b0);

      wait_idle();
      if (sb.pending() != 0)
         $display("%0t: %0d expected keys never arrived", $time, sb.pending());
      if (sb.errors == 0 && sb.pending() == 0)
         $display("PASS nec_ir_frame_decoder");
      else
         $display("FAIL nec_ir_frame_decoder");
      $finish;
   end

   // Far beyond any correct run, even with every stall at its longest.
   initial begin
      #2_000_000;
      $display("FAIL nec_ir_frame_decoder");
      $finish;
   end

endmodule
